@@ rtl/mbrtu_pkg.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU frame filter package
// Result kinds, register indexes, protocol constants and CRC helpers.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

	typedef enum logic [2:0] {
		KIND_LEN_DROP  = 3'd0,
		KIND_CRC_DROP  = 3'd1,
		KIND_ADDR_DROP = 3'd2,
		KIND_HANDLED   = 3'd3,
		KIND_UNSUPP    = 3'd4,
		KIND_REPLY     = 3'd5
	} kind_t;

	typedef enum logic {
		REG_DEV_ADDR = 1'b0,
		REG_FROZEN   = 1'b1
	} reg_idx_t;

	localparam logic [7:0]  BCAST_ADDR       = 8'h00;
	localparam logic [7:0]  EXC_FLAG         = 8'h80;
	localparam logic [7:0]  EXC_ILLEGAL_FUNC = 8'h01;
	localparam logic [15:0] CRC_INIT         = 16'hFFFF;
	localparam logic [15:0] CRC_POLY         = 16'hA001;
	localparam logic [7:0]  DEV_ADDR_RST     = 8'h01;

	// result index within one verdict run: verdict, then five reply bytes
	localparam logic [2:0]  IDX_VERDICT      = 3'd0;
	localparam logic [2:0]  IDX_ADDR         = 3'd1;
	localparam logic [2:0]  IDX_FUNC         = 3'd2;
	localparam logic [2:0]  IDX_CODE         = 3'd3;
	localparam logic [2:0]  IDX_CRC_LO       = 3'd4;
	localparam logic [2:0]  IDX_CRC_HI       = 3'd5;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] func;
		logic       bc;
		logic [7:0] addr;
		logic       reply;
	} verdict_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	function automatic logic is_supported(input logic [7:0] f);
		logic r;
		unique case (f)
			8'h03, 8'h04, 8'h05, 8'h10, 8'h25,
			8'h26, 8'h27, 8'h2A, 8'h2B, 8'h41: r = 1'b1;
			default:                           r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/mbrtu_if.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU frame filter channels
// Valid/ready channels for received bytes and for filter results.
// ----------------------------------------------------------------------------
interface mbrtu_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_end;

	modport source (output valid, output rx_byte, output frame_end, input ready);
	modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mbrtu_res_if;
	import mbrtu_pkg::*;
	logic       valid;
	logic       ready;
	kind_t      kind;
	logic [7:0] func_code;
	logic       is_broadcast;
	logic [7:0] tx_byte;
	logic       last;

	modport source (output valid, output kind, output func_code, output is_broadcast,
		output tx_byte, output last, input ready);
	modport sink   (input valid, input kind, input func_code, input is_broadcast,
		input tx_byte, input last, output ready);
endinterface

@@ rtl/mbrtu_frame.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU frame tracker
// Input register, running CRC, two-byte delay line and end-of-frame verdict.
// ----------------------------------------------------------------------------
module mbrtu_frame #(
	parameter int MAX_FRAME = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	mbrtu_rx_if.sink            rx,
	input  logic [7:0]          dev_addr,
	input  logic                frozen,
	input  logic                emit_free,
	output logic                vd_load,
	output mbrtu_pkg::verdict_t vd
);
	import mbrtu_pkg::*;

	localparam int CW = $clog2(MAX_FRAME + 1);

	logic          s1_valid;
	logic [7:0]    byte_s1;
	logic          end_s1;
	logic          s1_go;

	logic [15:0]   crc_q, crc_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic [7:0]    addr_q, addr_n;
	logic [7:0]    func_q, func_n;
	logic [7:0]    dly0_q, dly0_n;
	logic [7:0]    dly1_q, dly1_n;
	logic          ovr_q, ovr_n;
	logic          bc;

	assign s1_go    = s1_valid && (!end_s1 || emit_free);
	assign rx.ready = !s1_valid || s1_go;
	assign vd_load  = s1_go && end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			s1_valid <= 1'b1;
		end else if (s1_go) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
			end_s1  <= rx.frame_end;
		end
	end

	always_comb begin
		crc_n  = crc_q;
		cnt_n  = cnt_q;
		addr_n = addr_q;
		func_n = func_q;
		dly0_n = dly0_q;
		dly1_n = dly1_q;
		ovr_n  = ovr_q;
		if (cnt_q == CW'(MAX_FRAME)) begin
			ovr_n = 1'b1;
		end else begin
			if (cnt_q >= CW'(2))
				crc_n = crc_byte(crc_q, dly0_q);
			dly0_n = dly1_q;
			dly1_n = byte_s1;
			if (cnt_q == CW'(0))
				addr_n = byte_s1;
			else if (cnt_q == CW'(1))
				func_n = byte_s1;
			cnt_n = cnt_q + CW'(1);
		end
	end

	always_comb begin
		bc       = (addr_n == BCAST_ADDR);
		vd.func  = func_n;
		vd.bc    = bc;
		vd.addr  = addr_n;
		vd.reply = 1'b0;
		priority if (ovr_n || cnt_n < CW'(2)) begin
			vd.kind = KIND_LEN_DROP;
			vd.func = 8'h00;
			vd.bc   = 1'b0;
		end else if ({dly1_n, dly0_n} != crc_n) begin
			vd.kind = KIND_CRC_DROP;
		end else if (addr_n != dev_addr && !bc) begin
			vd.kind = KIND_ADDR_DROP;
		end else if (is_supported(func_n)) begin
			vd.kind = KIND_HANDLED;
		end else begin
			vd.kind  = KIND_UNSUPP;
			vd.reply = !bc && !frozen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			cnt_q  <= '0;
			addr_q <= '0;
			func_q <= '0;
			dly0_q <= '0;
			dly1_q <= '0;
			ovr_q  <= 1'b0;
		end else if (s1_go) begin
			if (end_s1) begin
				crc_q  <= CRC_INIT;
				cnt_q  <= '0;
				addr_q <= '0;
				func_q <= '0;
				dly0_q <= '0;
				dly1_q <= '0;
				ovr_q  <= 1'b0;
			end else begin
				crc_q  <= crc_n;
				cnt_q  <= cnt_n;
				addr_q <= addr_n;
				func_q <= func_n;
				dly0_q <= dly0_n;
				dly1_q <= dly1_n;
				ovr_q  <= ovr_n;
			end
		end
	end

endmodule

@@ rtl/mbrtu_emit.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU result emitter
// Holds one verdict, sends it and the optional exception reply bytes.
// ----------------------------------------------------------------------------
module mbrtu_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vd_load,
	input  mbrtu_pkg::verdict_t vd,
	output logic                emit_free,
	mbrtu_res_if.source         res
);
	import mbrtu_pkg::*;

	logic        valid_q;
	logic [2:0]  idx_q;
	logic [2:0]  last_idx_q;
	kind_t       kind_q;
	logic [7:0]  func_q;
	logic        bc_q;
	logic [7:0]  addr_q;
	logic [15:0] crc_q;
	logic [1:0]  ph_q;
	logic        at_last;

	assign at_last   = (idx_q == last_idx_q);
	assign emit_free = !valid_q || (res.ready && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			idx_q      <= IDX_VERDICT;
			last_idx_q <= IDX_VERDICT;
			ph_q       <= 2'd2;
		end else begin
			if (vd_load) begin
				valid_q    <= 1'b1;
				idx_q      <= IDX_VERDICT;
				last_idx_q <= vd.reply ? IDX_CRC_HI : IDX_VERDICT;
			end else if (valid_q && res.ready) begin
				if (at_last)
					valid_q <= 1'b0;
				else
					idx_q <= idx_q + 3'd1;
			end
			if (vd_load)
				ph_q <= 2'd0;
			else if (ph_q != 2'd2)
				ph_q <= ph_q + 2'd1;
		end
	end

	// reply CRC: address on load, then function|0x80 and the exception code
	always_ff @(posedge clk) begin
		if (vd_load) begin
			kind_q <= vd.kind;
			func_q <= vd.func;
			bc_q   <= vd.bc;
			addr_q <= vd.addr;
			crc_q  <= crc_byte(CRC_INIT, vd.addr);
		end else if (ph_q == 2'd0) begin
			crc_q <= crc_byte(crc_q, func_q | EXC_FLAG);
		end else if (ph_q == 2'd1) begin
			crc_q <= crc_byte(crc_q, EXC_ILLEGAL_FUNC);
		end
	end

	assign res.valid        = valid_q;
	assign res.func_code    = func_q;
	assign res.is_broadcast = bc_q;
	assign res.last         = at_last;
	assign res.kind         = (idx_q == IDX_VERDICT) ? kind_q : KIND_REPLY;

	always_comb begin
		unique case (idx_q)
			IDX_ADDR:   res.tx_byte = addr_q;
			IDX_FUNC:   res.tx_byte = func_q | EXC_FLAG;
			IDX_CODE:   res.tx_byte = EXC_ILLEGAL_FUNC;
			IDX_CRC_LO: res.tx_byte = crc_q[7:0];
			IDX_CRC_HI: res.tx_byte = crc_q[15:8];
			default:    res.tx_byte = 8'h00;
		endcase
	end

endmodule

@@ rtl/modbus_rtu_frame_filter.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU frame filter
// CRC-16/MODBUS frame check, address filter and illegal-function reply.
// ----------------------------------------------------------------------------
// rx carries one received byte per item, frame_end set on the final byte.
// res carries one item per verdict (length, CRC or address drop, handled,
// unsupported) and, for an unsupported function addressed to this device
// while not frozen, five more items with the exception reply bytes.
// last marks the final item of a frame's results.
// cfg_we/cfg_idx/cfg_wdata write the device address (index 0) and the
// frozen flag (index 1); write only while no frame result is pending.
// rx takes one byte per cycle while no frame end is held in the input register;
// the verdict is on res from the edge at which the end byte leaves that
// register, and the emitter holds it there until it is taken.
// Reply bytes follow the verdict, one per cycle while res is ready.
// A frame end waits in the input register while the previous frame's
// results (one, or six with a reply) are still being taken, so a stalled
// res backs up into rx after one held byte.
// Reset clears the frame state, sets device address 1 and frozen 0.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_filter #(
	parameter int MAX_FRAME = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	mbrtu_rx_if.sink    rx,
	mbrtu_res_if.source res,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [7:0]  cfg_wdata
);
	import mbrtu_pkg::*;

	logic       [7:0] dev_addr_q;
	logic             frozen_q;
	logic             emit_free;
	logic             vd_load;
	verdict_t         vd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RST;
			frozen_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_DEV_ADDR: dev_addr_q <= cfg_wdata;
				REG_FROZEN:   frozen_q   <= cfg_wdata[0];
				default:      ;
			endcase
		end
	end

	mbrtu_frame #(
		.MAX_FRAME (MAX_FRAME)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.dev_addr  (dev_addr_q),
		.frozen    (frozen_q),
		.emit_free (emit_free),
		.vd_load   (vd_load),
		.vd        (vd)
	);

	mbrtu_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.vd_load   (vd_load),
		.vd        (vd),
		.emit_free (emit_free),
		.res       (res)
	);

endmodule
